FILE: rtl/dpdc_pkg.sv
// ----------------------------------------------------------------------------
// dpdc_pkg
// Shared types and constants for the dark-count map: register indexes,
// register reset values, operation codes and the result word.
// ----------------------------------------------------------------------------
package dpdc_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DARK_COUNT = 8'd1;

  localparam logic [7:0]  DARK_THRESHOLD_RST = 8'd10;
  localparam logic [15:0] MIN_DARK_COUNT_RST = 16'd3;

  // operation codes
  localparam logic OP_ACCUM   = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  // result queue
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

  typedef struct packed {
    logic [7:0]  pixel_out;
    logic        is_dark;
    logic [15:0] dark_count;
    logic        defective;
  } result_t;

  typedef enum logic {
    CLR_SWEEP,
    CLR_DONE
  } clr_state_e;

endpackage

FILE: rtl/dpdc_count_mem.sv
// ----------------------------------------------------------------------------
// dpdc_count_mem
// Simple dual-port counter memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dpdc_count_mem #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/dpdc_clear_seq.sv
// ----------------------------------------------------------------------------
// dpdc_clear_seq
// Post-reset clearing pass: walks every counter address once, one per cycle,
// and writes zero. Busy until the last address has been written.
// ----------------------------------------------------------------------------
module dpdc_clear_seq #(
  parameter int unsigned PIXELS = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  output logic              busy_o,
  output logic              wr_en_o,
  output logic [ADDR_W-1:0] addr_o
);

  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(PIXELS - 1);

  dpdc_pkg::clr_state_e state_q, state_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpdc_pkg::CLR_SWEEP;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    busy_o  = 1'b0;
    wr_en_o = 1'b0;
    case (state_q)
      dpdc_pkg::CLR_SWEEP: begin
        busy_o  = 1'b1;
        wr_en_o = 1'b1;
        if (addr_q == LastAddr) begin
          state_d = dpdc_pkg::CLR_DONE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      dpdc_pkg::CLR_DONE: begin
        busy_o  = 1'b0;
      end
      default: begin
        state_d = dpdc_pkg::CLR_SWEEP;
      end
    endcase
  end

  assign addr_o = addr_q;

endmodule

FILE: rtl/dpdc_result_fifo.sv
// ----------------------------------------------------------------------------
// dpdc_result_fifo
// Small result queue between the update stage and the output port, so the
// pipeline keeps its slot while the consumer stalls.
// ----------------------------------------------------------------------------
module dpdc_result_fifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  dpdc_pkg::result_t                    push_data_i,
  input  logic                                 pop_i,
  output logic                                 valid_o,
  output dpdc_pkg::result_t                    data_o,
  output logic [dpdc_pkg::RES_CNT_W-1:0]       count_o
);

  dpdc_pkg::result_t                    buf_q [dpdc_pkg::RES_DEPTH];
  logic [dpdc_pkg::RES_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [dpdc_pkg::RES_CNT_W-1:0]       count_q, count_d;
  logic                                 do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + dpdc_pkg::RES_CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - dpdc_pkg::RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + dpdc_pkg::RES_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + dpdc_pkg::RES_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/dead_pixel_dark_count_map_top.sv
// ----------------------------------------------------------------------------
// dead_pixel_dark_count_map_top
// Per-pixel saturating dark counter map with readout-and-clear.
// ----------------------------------------------------------------------------
// After reset the block clears every counter, one address per clock;
// in_ready_o stays low during that pass while configuration writes are
// taken as usual. From then on it takes one input word per clock while
// in_ready_o is high: the counter memory is read at accept, the updated
// count is computed and written back the next cycle, and a back-to-back
// access to the same pixel takes its count from a forwarding register
// instead of the memory. A result word passes through the update stage
// and the result queue before it is presented. A four-entry result queue
// absorbs output stalls; outside the clearing pass, in_ready_o drops only
// when that queue and the update stage together hold four words.
module dead_pixel_dark_count_map_top #(
  parameter int unsigned PIXELS     = 65536,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dpdc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dpdc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               op_i,
  input  logic [15:0]                        pixel_index_i,
  input  logic [7:0]                         pixel_value_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [7:0]                         pixel_out_o,
  output logic                               is_dark_o,
  output logic [15:0]                        dark_count_o,
  output logic                               defective_o
);

  localparam int unsigned AddrW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned IdxExtW = 25;

  // configuration registers
  logic [7:0]  threshold_q;
  logic [15:0] min_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= dpdc_pkg::DARK_THRESHOLD_RST;
      min_count_q <= dpdc_pkg::MIN_DARK_COUNT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == dpdc_pkg::REG_DARK_THRESHOLD) begin
        threshold_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == dpdc_pkg::REG_MIN_DARK_COUNT) begin
        min_count_q <= cfg_data_i[15:0];
      end
    end
  end

  // clearing pass
  logic             clr_busy;
  logic             clr_wr;
  logic [AddrW-1:0] clr_addr;

  dpdc_clear_seq #(
    .PIXELS (PIXELS),
    .ADDR_W (AddrW)
  ) u_clear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .busy_o  (clr_busy),
    .wr_en_o (clr_wr),
    .addr_o  (clr_addr)
  );

  // accept stage
  logic [dpdc_pkg::RES_CNT_W-1:0] fifo_count;
  logic                           in_accept;
  logic [IdxExtW-1:0]             idx_ext;
  logic                           in_range;
  logic [AddrW-1:0]               rd_addr;

  logic                           s1_valid_q;
  logic                           s1_op_q;
  logic                           s1_in_range_q;
  logic                           s1_dark_q;
  logic [7:0]                     s1_value_q;
  logic [AddrW-1:0]               s1_addr_q;

  // hold off when every result slot is spoken for
  assign in_ready_o = !clr_busy &&
      ((fifo_count + dpdc_pkg::RES_CNT_W'(s1_valid_q)) <
       dpdc_pkg::RES_CNT_W'(dpdc_pkg::RES_DEPTH));
  assign in_accept  = in_valid_i && in_ready_o;
  assign idx_ext    = IdxExtW'(pixel_index_i);
  assign in_range   = (idx_ext < IdxExtW'(PIXELS));
  assign rd_addr    = idx_ext[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q       <= op_i;
      s1_in_range_q <= in_range;
      s1_dark_q     <= (pixel_value_i < threshold_q);
      s1_value_q    <= pixel_value_i;
      s1_addr_q     <= rd_addr;
    end
  end

  // counter memory
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;

  logic                  s1_wr;
  logic [COUNT_BITS-1:0] s1_wdata;

  assign mem_we    = clr_wr || s1_wr;
  assign mem_waddr = clr_busy ? clr_addr : s1_addr_q;
  assign mem_wdata = clr_busy ? '0 : s1_wdata;

  dpdc_count_mem #(
    .DEPTH  (PIXELS),
    .ADDR_W (AddrW),
    .DATA_W (COUNT_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  // update stage with forwarding of the most recent write
  logic                  fwd_valid_q;
  logic [AddrW-1:0]      fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_cnt_q;

  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [15:0]           res_cnt_clip;
  dpdc_pkg::result_t     s1_result;

  assign cur_cnt = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_cnt_q : mem_rdata;
  // saturate at all ones
  assign inc_cnt = (s1_dark_q && !(&cur_cnt)) ? (cur_cnt + COUNT_BITS'(1)) : cur_cnt;

  always_comb begin
    s1_wr    = s1_valid_q && s1_in_range_q;
    s1_wdata = '0;
    res_cnt  = '0;
    case (s1_op_q)
      dpdc_pkg::OP_ACCUM: begin
        s1_wdata = inc_cnt;
        res_cnt  = s1_in_range_q ? inc_cnt : '0;
      end
      dpdc_pkg::OP_READOUT: begin
        s1_wdata = '0;
        res_cnt  = s1_in_range_q ? cur_cnt : '0;
      end
      default: begin
        s1_wr = 1'b0;
      end
    endcase
  end

  generate
    if (COUNT_BITS > 16) begin : g_clip
      assign res_cnt_clip = (|res_cnt[COUNT_BITS-1:16]) ? 16'hFFFF : res_cnt[15:0];
    end else begin : g_noclip
      assign res_cnt_clip = 16'(res_cnt);
    end
  endgenerate

  assign s1_result.pixel_out  = (s1_op_q == dpdc_pkg::OP_ACCUM) ? s1_value_q : 8'd0;
  assign s1_result.is_dark    = (s1_op_q == dpdc_pkg::OP_ACCUM) ? s1_dark_q : 1'b0;
  assign s1_result.dark_count = res_cnt_clip;
  assign s1_result.defective  = (32'(res_cnt) >= 32'(min_count_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_wr) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      fwd_addr_q <= s1_addr_q;
      fwd_cnt_q  <= s1_wdata;
    end
  end

  // result queue
  dpdc_pkg::result_t out_word;

  dpdc_result_fifo u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (s1_result),
    .pop_i       (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (out_word),
    .count_o     (fifo_count)
  );

  assign pixel_out_o  = out_word.pixel_out;
  assign is_dark_o    = out_word.is_dark;
  assign dark_count_o = out_word.dark_count;
  assign defective_o  = out_word.defective;

endmodule
